/* sv/mst_pkg.sv */
// Shared constants, codes and inter-module types for the multiplexed software timers.
package mst_pkg;

  localparam int TIMERS      = 8;
  localparam int MAX_RESULTS = 8;
  localparam int TIDX_W      = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W       = $clog2(TIMERS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int DL_W        = 32;
  localparam int FUNC_W      = 2;
  localparam int INDEX_W     = 3;
  localparam int KIND_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 2'd0,
    FN_STOP  = 2'd1,
    FN_TICK  = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KD_NONE    = 2'd0,
    KD_REJECT  = 2'd1,
    KD_EXPIRED = 2'd2,
    KD_QUERY   = 2'd3
  } kind_t;

  typedef struct packed {
    logic start;
    logic clear;
  } scan_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [TIDX_W-1:0] best_idx;
    logic [DL_W-1:0]   best_dl;
  } scan_stat_t;

endpackage

/* sv/mst_chan_if.sv */
// Valid/ready channel interfaces for the request and result streams.
interface mst_in_if;
  logic                        valid;
  logic                        ready;
  logic [mst_pkg::FUNC_W-1:0]  func;
  logic [mst_pkg::INDEX_W-1:0] timer_index;
  logic [mst_pkg::DL_W-1:0]    duration;

  modport source (output valid, func, timer_index, duration, input ready);
  modport sink (input valid, func, timer_index, duration, output ready);
endinterface

interface mst_out_if;
  logic                        valid;
  logic                        ready;
  logic [mst_pkg::KIND_W-1:0]  kind;
  logic [mst_pkg::INDEX_W-1:0] which_timer;
  logic                        has_ended;
  logic                        last;

  modport source (output valid, kind, which_timer, has_ended, last, input ready);
  modport sink (input valid, kind, which_timer, has_ended, last, output ready);
endinterface

/* sv/multiplexed_software_timers_core.sv */
// Top level: request sequencer, timer state and result register of the software timers.
//
//  Channel   Direction  Carries
//  in_chan   sink       func, timer_index, duration
//  out_chan  source     kind, which_timer, has_ended, last
//
// A query, a rejected start, a stop that leaves no timer running and a tick with nothing
// due need no search. A start, a stop that leaves timers running and each expiry on a tick
// (but the one that stops the last running timer) re-walk the deadline RAM through its
// read port, one entry a cycle.
// Reset is synchronous and active low; after it no timer runs and the counter is zero.
// A stalled result holds the sequencer only when a further result must be loaded.
module multiplexed_software_timers_core (
  input  logic             clk,
  input  logic             rst_n,
  mst_in_if.sink           in_chan,
  mst_out_if.source        out_chan
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_REPLY = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [mst_pkg::TIMERS-1:0]  running_r, running_nxt;
  logic [mst_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [mst_pkg::DL_W-1:0]    counter_r, counter_nxt;
  logic [mst_pkg::TIDX_W-1:0]  idx_r, idx_nxt;
  logic [mst_pkg::DL_W-1:0]    dur_r, dur_nxt;
  logic                        ret_tick_r, ret_tick_nxt;
  mst_pkg::kind_t              rkind_r, rkind_nxt;
  logic [mst_pkg::INDEX_W-1:0] rwhich_r, rwhich_nxt;
  logic                        rended_r, rended_nxt;
  logic                        pend_r, pend_nxt;
  logic [mst_pkg::TIDX_W-1:0]  pend_which_r, pend_which_nxt;
  logic [mst_pkg::NRES_W-1:0]  n_r, n_nxt;

  logic                        out_valid_r, out_valid_nxt;
  mst_pkg::kind_t              out_kind_r;
  logic [mst_pkg::INDEX_W-1:0] out_which_r;
  logic                        out_ended_r;
  logic                        out_last_r;

  logic                        out_load;
  mst_pkg::kind_t              ld_kind;
  logic [mst_pkg::INDEX_W-1:0] ld_which;
  logic                        ld_ended;
  logic                        ld_last;

  mst_pkg::scan_ctrl_t         scan_ctrl;
  mst_pkg::scan_stat_t         scan_st;
  logic [mst_pkg::TIDX_W-1:0]  rd_addr;
  logic [mst_pkg::DL_W-1:0]    rd_data;
  logic                        ram_we;

  logic                        accept;
  logic                        slot_free;
  logic                        in_idx_ok;
  logic [mst_pkg::TIDX_W-1:0]  in_tidx;
  logic                        in_running;
  logic                        due;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign in_idx_ok     = int'(in_chan.timer_index) < mst_pkg::TIMERS;
  assign in_tidx       = mst_pkg::TIDX_W'(in_chan.timer_index);
  assign in_running    = in_idx_ok && running_r[in_tidx];

  // The earliest running deadline is due once it is at or before the counter.
  assign due = (count_r != '0) && (scan_st.best_dl <= counter_r) &&
               (n_r < mst_pkg::NRES_W'(mst_pkg::MAX_RESULTS));

  mst_ram #(
    .WIDTH (mst_pkg::DL_W),
    .DEPTH (mst_pkg::TIMERS)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (counter_r + dur_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mst_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (scan_ctrl),
    .running (running_r),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .stat    (scan_st)
  );

  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    count_nxt      = count_r;
    counter_nxt    = counter_r;
    idx_nxt        = idx_r;
    dur_nxt        = dur_r;
    ret_tick_nxt   = ret_tick_r;
    rkind_nxt      = rkind_r;
    rwhich_nxt     = rwhich_r;
    rended_nxt     = rended_r;
    pend_nxt       = pend_r;
    pend_which_nxt = pend_which_r;
    n_nxt          = n_r;
    scan_ctrl      = '0;
    ram_we         = 1'b0;
    out_load       = 1'b0;
    ld_kind        = mst_pkg::KD_NONE;
    ld_which       = '0;
    ld_ended       = 1'b0;
    ld_last        = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rkind_nxt  = mst_pkg::KD_NONE;
          rwhich_nxt = '0;
          rended_nxt = 1'b0;
          idx_nxt    = in_tidx;
          dur_nxt    = in_chan.duration;
          case (in_chan.func)
            mst_pkg::FN_START: begin
              if (in_idx_ok && (count_r < mst_pkg::CNT_W'(mst_pkg::TIMERS))) begin
                state_nxt = ST_START;
              end else begin
                rkind_nxt = mst_pkg::KD_REJECT;
                state_nxt = ST_REPLY;
              end
            end
            mst_pkg::FN_STOP: begin
              state_nxt = ST_REPLY;
              if (in_running) begin
                running_nxt[in_tidx] = 1'b0;
                count_nxt            = count_r - mst_pkg::CNT_W'(1);
                if (count_r == mst_pkg::CNT_W'(1)) begin
                  counter_nxt     = '0;
                  scan_ctrl.clear = 1'b1;
                end else begin
                  scan_ctrl.start = 1'b1;
                  ret_tick_nxt    = 1'b0;
                  state_nxt       = ST_SCAN;
                end
              end
            end
            mst_pkg::FN_TICK: begin
              if (count_r == '0) begin
                state_nxt = ST_REPLY;
              end else begin
                counter_nxt = counter_r + mst_pkg::DL_W'(1);
                n_nxt       = '0;
                pend_nxt    = 1'b0;
                state_nxt   = ST_CHECK;
              end
            end
            mst_pkg::FN_QUERY: begin
              rkind_nxt  = mst_pkg::KD_QUERY;
              rwhich_nxt = in_chan.timer_index;
              rended_nxt = !in_running;
              state_nxt  = ST_REPLY;
            end
            default: begin
              state_nxt = ST_REPLY;
            end
          endcase
        end
      end

      ST_START: begin
        // Restarting a running timer re-arms it without changing the count.
        ram_we = 1'b1;
        if (!running_r[idx_r]) begin
          running_nxt[idx_r] = 1'b1;
          count_nxt          = count_r + mst_pkg::CNT_W'(1);
        end
        scan_ctrl.start = 1'b1;
        ret_tick_nxt    = 1'b0;
        state_nxt       = ST_SCAN;
      end

      ST_SCAN: begin
        if (scan_st.done) begin
          state_nxt = ret_tick_r ? ST_CHECK : ST_REPLY;
        end
      end

      ST_CHECK: begin
        // An expiry is held back until the next check tells whether it is the last.
        if (due) begin
          if (!pend_r || slot_free) begin
            if (pend_r) begin
              out_load = 1'b1;
              ld_kind  = mst_pkg::KD_EXPIRED;
              ld_which = mst_pkg::INDEX_W'(pend_which_r);
              ld_last  = 1'b0;
            end
            running_nxt[scan_st.best_idx] = 1'b0;
            count_nxt      = count_r - mst_pkg::CNT_W'(1);
            pend_nxt       = 1'b1;
            pend_which_nxt = scan_st.best_idx;
            n_nxt          = n_r + mst_pkg::NRES_W'(1);
            if (count_r == mst_pkg::CNT_W'(1)) begin
              counter_nxt     = '0;
              scan_ctrl.clear = 1'b1;
            end else begin
              scan_ctrl.start = 1'b1;
              ret_tick_nxt    = 1'b1;
              state_nxt       = ST_SCAN;
            end
          end
        end else if (slot_free) begin
          out_load  = 1'b1;
          ld_kind   = pend_r ? mst_pkg::KD_EXPIRED : mst_pkg::KD_NONE;
          ld_which  = pend_r ? mst_pkg::INDEX_W'(pend_which_r) : '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      ST_REPLY: begin
        if (slot_free) begin
          out_load  = 1'b1;
          ld_kind   = rkind_r;
          ld_which  = rwhich_r;
          ld_ended  = rended_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= '0;
      count_r     <= '0;
      counter_r   <= '0;
      ret_tick_r  <= 1'b0;
      pend_r      <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      count_r     <= count_nxt;
      counter_r   <= counter_nxt;
      ret_tick_r  <= ret_tick_nxt;
      pend_r      <= pend_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    dur_r        <= dur_nxt;
    rkind_r      <= rkind_nxt;
    rwhich_r     <= rwhich_nxt;
    rended_r     <= rended_nxt;
    pend_which_r <= pend_which_nxt;
    if (out_load) begin
      out_kind_r  <= ld_kind;
      out_which_r <= ld_which;
      out_ended_r <= ld_ended;
      out_last_r  <= ld_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.which_timer = out_which_r;
  assign out_chan.has_ended   = out_ended_r;
  assign out_chan.last        = out_last_r;

  // The running count always matches the number of running timers.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == mst_pkg::CNT_W'($countones(running_r)))
    else $error("running count out of step with running timers");

  // With no timer running the counter rests at zero.
  a_counter_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count_r == '0) |-> (counter_r == '0))
    else $error("counter moving with no timer running");

  // Between requests the earliest pointer names a running timer.
  a_earliest_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count_r != '0) |-> running_r[scan_st.best_idx])
    else $error("earliest timer is not running");

  // A finished search is only ever awaited by the search state.
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_st.done |-> (state_r == ST_SCAN))
    else $error("search finished outside the search state");

  // A tick never produces more expiries than a transaction may carry.
  a_expiry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= mst_pkg::NRES_W'(mst_pkg::MAX_RESULTS))
    else $error("too many expiries on one tick");

endmodule

/* sv/mst_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/mst_scan.sv */
// Earliest-deadline search: walks the deadline RAM one entry a cycle through one comparator.
module mst_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mst_pkg::scan_ctrl_t        ctrl,
  input  logic [mst_pkg::TIMERS-1:0] running,
  input  logic [mst_pkg::DL_W-1:0]   rd_data,
  output logic [mst_pkg::TIDX_W-1:0] rd_addr,
  output mst_pkg::scan_stat_t        stat
);

  logic                       issuing_r, issuing_nxt;
  logic [mst_pkg::TIDX_W-1:0] addr_r, addr_nxt;
  logic                       cmp_valid_r, cmp_valid_nxt;
  logic                       cmp_last_r, cmp_last_nxt;
  logic [mst_pkg::TIDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic                       found_r, found_nxt;
  logic [mst_pkg::TIDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [mst_pkg::DL_W-1:0]   best_dl_r, best_dl_nxt;
  logic                       done_r, done_nxt;
  logic                       take;

  assign rd_addr = addr_r;

  // Strictly earlier wins, so on equal deadlines the lower-numbered timer is kept.
  assign take = cmp_valid_r && running[cmp_idx_r] && (!found_r || (rd_data < best_dl_r));

  always_comb begin
    issuing_nxt   = issuing_r;
    addr_nxt      = addr_r;
    cmp_valid_nxt = issuing_r;
    cmp_idx_nxt   = addr_r;
    cmp_last_nxt  = (addr_r == mst_pkg::TIDX_W'(mst_pkg::TIMERS - 1));
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_dl_nxt   = best_dl_r;
    done_nxt      = cmp_valid_r && cmp_last_r;

    if (issuing_r) begin
      if (cmp_last_nxt) begin
        issuing_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + mst_pkg::TIDX_W'(1);
      end
    end

    if (take) begin
      found_nxt    = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_dl_nxt  = rd_data;
    end

    if (ctrl.start) begin
      issuing_nxt  = 1'b1;
      addr_nxt     = '0;
      found_nxt    = 1'b0;
      best_idx_nxt = '0;
    end else if (ctrl.clear) begin
      best_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r   <= 1'b0;
      addr_r      <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      done_r      <= 1'b0;
    end else begin
      issuing_r   <= issuing_nxt;
      addr_r      <= addr_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      found_r     <= found_nxt;
      best_idx_r  <= best_idx_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    best_dl_r  <= best_dl_nxt;
  end

  assign stat.done     = done_r;
  assign stat.best_idx = best_idx_r;
  assign stat.best_dl  = best_dl_r;

endmodule
